>>> rtl/core/cde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types, codes and defaults for the circular deque engine.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int DEQ_CAPACITY = 128;

  typedef enum logic [2:0] {
    OP_PEEK       = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_HEAD   = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_REVERSE    = 3'd6,
    OP_SORT       = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_code_t;

  // Read port addressing: both ends of the deque, or the working pair.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_ENDS,
    RD_PAIR
  } rd_sel_t;

  // Swap writes: word from the first slot into the second, then the reverse.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_A_AT_J,
    WR_B_AT_I
  } wr_sel_t;

  typedef struct packed {
    logic    load;       // capture the input item
    logic    apply;      // perform the queue update of the captured opcode
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    step_rev;   // advance the reverse pointers inward
    logic    step_sort;  // advance to the next bubble sort pair
    logic    out_load;   // capture the result into the output register
  } cde_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    few;        // fewer than two elements
    logic    pair_lt;    // first offset below second offset
    logic    sort_done;  // no pass left to run
    logic    pair_gt;    // first word of the pair greater than the second
  } cde_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/circular_deque_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_engine_unit
// Double-ended queue of signed 32-bit words in a circular store, with
// push, pop, peek, clear, in-place reverse and in-place ascending sort.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------
//  in      | input     | in_valid, in_ready, in_opcode, in_data_value
//  out     | output    | out_valid, out_ready, out_status, out_front_value,
//          |           | out_back_value, out_element_count, out_is_empty,
//          |           | out_is_full
//
// Peek, push, pop and clear go through accept, update, a read of
// both ends through the two store read ports, and the load of the result register.
// Reverse reads each swapped pair and writes both words back; sort reads and
// compares each of n(n-1)/2 pairs for n elements and writes both back on a swap.
// Synchronous active-low reset clears head, count and out_valid and sets in_ready;
// the store itself is not cleared. A stalled result holds the output register; the
// next item is taken meanwhile and waits in its last step until the register frees.
// ----------------------------------------------------------------------------
module circular_deque_engine_unit #(
  parameter int CAPACITY = cde_pkg::DEQ_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [31:0] in_data_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_front_value,
  output logic signed [31:0]      out_back_value,
  output logic [7:0]              out_element_count,
  output logic                    out_is_empty,
  output logic                    out_is_full
);
  import cde_pkg::*;

  cde_cmd_t  cmd;
  cde_stat_t stat;

  cde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cde_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_data_value     (in_data_value),
    .out_status        (out_status),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full)
  );

endmodule
`default_nettype wire

>>> rtl/core/cde_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cde_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cde_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cde_datapath
// Head and count registers, element store, working pointers and result
// register of the circular deque engine.
// ----------------------------------------------------------------------------
module cde_datapath #(
  parameter int CAPACITY = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cde_pkg::cde_cmd_t   cmd,
  output cde_pkg::cde_stat_t       stat,
  input  wire logic [2:0]          in_opcode,
  input  wire logic signed [31:0]  in_data_value,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_front_value,
  output logic signed [31:0]       out_back_value,
  output logic [7:0]               out_element_count,
  output logic                     out_is_empty,
  output logic                     out_is_full
);
  import cde_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_W  = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

  // Wrap an offset from the head into a store slot.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h,
                                            input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[IW-1:0];
  endfunction

  opcode_t          op_r;
  logic [31:0]      data_r;
  logic [IW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [IW-1:0]    j_r, j_nxt;
  logic [IW-1:0]    end_r, end_nxt;
  status_code_t     status_r, status_nxt;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [31:0]      wr_data;
  logic [IW-1:0]    rd_addr_a, rd_addr_b;
  logic [31:0]      rd_data_a, rd_data_b;

  logic             empty, full;
  logic [IW-1:0]    last_off;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CAP_C);
  assign last_off = IW'(count_r - 1'b1);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    end_nxt    = end_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = slot_of(head_r, j_r);
    wr_data    = rd_data_a;

    if (cmd.apply) begin
      status_nxt = STATUS_OK;
      case (op_r)
        OP_PUSH_REAR: begin
          if (full) begin
            status_nxt = STATUS_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = slot_of(head_r, IW'(count_r));
            wr_data   = data_r;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = STATUS_OVERFLOW;
          end else begin
            head_nxt  = (head_r == '0) ? LAST_I : head_r - 1'b1;
            wr_en     = 1'b1;
            wr_addr   = head_nxt;
            wr_data   = data_r;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_HEAD: begin
          if (empty) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
            head_nxt  = (count_nxt == '0) ? '0 : slot_of(head_r, IW'(1));
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
            if (count_nxt == '0) begin
              head_nxt = '0;
            end
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
          head_nxt  = '0;
        end
        OP_REVERSE: begin
          i_nxt = '0;
          j_nxt = last_off;
        end
        OP_SORT: begin
          i_nxt   = '0;
          j_nxt   = IW'(1);
          end_nxt = last_off;
        end
        OP_PEEK: begin
        end
        default: begin
        end
      endcase
    end

    case (cmd.wr_sel)
      WR_A_AT_J: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(head_r, j_r);
        wr_data = rd_data_a;
      end
      WR_B_AT_I: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(head_r, i_r);
        wr_data = rd_data_b;
      end
      default: begin
      end
    endcase

    if (cmd.step_rev) begin
      i_nxt = i_r + 1'b1;
      j_nxt = j_r - 1'b1;
    end

    // A pass ends when the pair reaches the last unsorted offset.
    if (cmd.step_sort) begin
      if (j_r == end_r) begin
        end_nxt = end_r - 1'b1;
        i_nxt   = '0;
        j_nxt   = IW'(1);
      end else begin
        i_nxt = i_r + 1'b1;
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd.rd_sel == RD_ENDS) begin
      rd_addr_a = head_r;
      rd_addr_b = slot_of(head_r, last_off);
    end else begin
      rd_addr_a = slot_of(head_r, i_r);
      rd_addr_b = slot_of(head_r, j_r);
    end
  end

  cde_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (cmd.rd_sel != RD_NONE),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    end_r    <= end_nxt;
    status_r <= status_nxt;
    if (cmd.load) begin
      op_r   <= opcode_t'(in_opcode);
      data_r <= in_data_value;
    end
    if (cmd.out_load) begin
      out_status        <= status_r;
      out_front_value   <= empty ? -32'sd1 : $signed(rd_data_a);
      out_back_value    <= empty ? -32'sd1 : $signed(rd_data_b);
      out_element_count <= 8'(count_r);
      out_is_empty      <= empty;
      out_is_full       <= full;
    end
  end

  assign stat.op        = op_r;
  assign stat.few       = (count_r <= CW'(1));
  assign stat.pair_lt   = (i_r < j_r);
  assign stat.sort_done = (end_r == '0);
  assign stat.pair_gt   = ($signed(rd_data_a) > $signed(rd_data_b));

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < CAP_W)
    else $error("head index outside the store");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> head_r == '0)
    else $error("empty deque with nonzero head");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && status_nxt == STATUS_OK &&
    (op_r == OP_PUSH_REAR || op_r == OP_PUSH_FRONT) |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not grow the count");
`endif

endmodule
`default_nettype wire

>>> rtl/core/cde_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cde_ctrl
// Sequencer of the circular deque engine: input and output handshakes,
// queue update, reverse and bubble sort walks, and result read-out.
// ----------------------------------------------------------------------------
module cde_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire cde_pkg::cde_stat_t stat,
  output cde_pkg::cde_cmd_t       cmd
);
  import cde_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_REV,
    S_REV_RD,
    S_REV_WR,
    S_SORT,
    S_SORT_RD,
    S_SORT_WR,
    S_ENDS,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_NONE;
    cmd.wr_sel    = WR_NONE;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (stat.op == OP_REVERSE && !stat.few) begin
          state_nxt = S_REV;
        end else if (stat.op == OP_SORT && !stat.few) begin
          state_nxt = S_SORT;
        end else begin
          state_nxt = S_ENDS;
        end
      end
      S_REV: begin
        if (stat.pair_lt) begin
          cmd.rd_sel = RD_PAIR;
          state_nxt  = S_REV_RD;
        end else begin
          state_nxt = S_ENDS;
        end
      end
      S_REV_RD: begin
        cmd.wr_sel = WR_A_AT_J;
        state_nxt  = S_REV_WR;
      end
      S_REV_WR: begin
        cmd.wr_sel   = WR_B_AT_I;
        cmd.step_rev = 1'b1;
        state_nxt    = S_REV;
      end
      S_SORT: begin
        if (stat.sort_done) begin
          state_nxt = S_ENDS;
        end else begin
          cmd.rd_sel = RD_PAIR;
          state_nxt  = S_SORT_RD;
        end
      end
      S_SORT_RD: begin
        if (stat.pair_gt) begin
          cmd.wr_sel = WR_A_AT_J;
          state_nxt  = S_SORT_WR;
        end else begin
          cmd.step_sort = 1'b1;
          state_nxt     = S_SORT;
        end
      end
      S_SORT_WR: begin
        cmd.wr_sel    = WR_B_AT_I;
        cmd.step_sort = 1'b1;
        state_nxt     = S_SORT;
      end
      S_ENDS: begin
        cmd.rd_sel = RD_ENDS;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("input ready outside the idle state");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state_r == S_RESULT && !(out_valid_r && !out_ready))
    else $error("result loaded over a pending transfer");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready_r |=> !in_ready_r && state_r == S_APPLY)
    else $error("accepted item did not start the update");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular deque engine. A scoreboard class keeps
// its own copy of the deque, predicts the report of every accepted operation
// and checks each result transfer against it. Stimulus is a short directed
// sequence, then random episodes of churn, fill-and-drain and noise, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import cde_pkg::*;

  localparam int CAP          = DEQ_CAPACITY;
  localparam int ITEM_TARGET  = 1850;
  localparam int HOLD_AT_ITEM = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int SORT_DEPTH   = 24;

  typedef struct packed {
    opcode_t             cause_op;
    status_code_t        status;
    logic signed [31:0]  front_value;
    logic signed [31:0]  back_value;
    logic [7:0]          element_count;
    logic                is_empty;
    logic                is_full;
  } deque_report_t;

  class deque_scoreboard;
    logic signed [31:0] words [CAP];
    int                 head;
    int                 depth;
    deque_report_t      reports_due [$];
    int                 mismatches;

    function new();
      head = 0;
      depth = 0;
      mismatches = 0;
    endfunction

    function int slot(int offset);
      return (head + offset) % CAP;
    endfunction

    // Applies one accepted operation to the shadow deque and queues its report.
    function void note_transfer(opcode_t op, logic signed [31:0] value);
      deque_report_t      rep;
      status_code_t       st;
      int                 i;
      int                 j;
      int                 a;
      int                 b;
      logic signed [31:0] tmp;
      st = STATUS_OK;
      case (op)
        OP_PUSH_REAR: begin
          if (depth >= CAP) begin
            st = STATUS_OVERFLOW;
          end else begin
            words[slot(depth)] = value;
            depth++;
          end
        end
        OP_PUSH_FRONT: begin
          if (depth >= CAP) begin
            st = STATUS_OVERFLOW;
          end else begin
            head = (head + CAP - 1) % CAP;
            words[head] = value;
            depth++;
          end
        end
        OP_POP_HEAD: begin
          if (depth == 0) begin
            st = STATUS_UNDERFLOW;
          end else begin
            head = slot(1);
            depth--;
            if (depth == 0) head = 0;
          end
        end
        OP_POP_BACK: begin
          if (depth == 0) begin
            st = STATUS_UNDERFLOW;
          end else begin
            depth--;
            if (depth == 0) head = 0;
          end
        end
        OP_CLEAR: begin
          depth = 0;
          head = 0;
        end
        OP_REVERSE: begin
          i = 0;
          j = depth - 1;
          while (i < j) begin
            a = slot(i);
            b = slot(j);
            tmp = words[a];
            words[a] = words[b];
            words[b] = tmp;
            i++;
            j--;
          end
        end
        OP_SORT: begin
          for (i = 0; i + 1 < depth; i++) begin
            for (j = 0; j + 1 < depth - i; j++) begin
              a = slot(j);
              b = slot(j + 1);
              if (words[a] > words[b]) begin
                tmp = words[a];
                words[a] = words[b];
                words[b] = tmp;
              end
            end
          end
        end
        default: begin
        end
      endcase
      rep.cause_op = op;
      rep.status = st;
      rep.element_count = depth[7:0];
      rep.is_empty = (depth == 0);
      rep.is_full = (depth >= CAP);
      if (depth == 0) begin
        rep.front_value = -1;
        rep.back_value = -1;
      end else begin
        rep.front_value = words[head];
        rep.back_value = words[slot(depth - 1)];
      end
      reports_due.insert(reports_due.size(), rep);
    endfunction

    function void check_report(logic [1:0] status, logic signed [31:0] front,
                               logic signed [31:0] back, logic [7:0] count,
                               logic empty, logic full);
      deque_report_t exp;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing expected: status %0d count %0d",
                   $time, status, count);
        return;
      end
      exp = reports_due[0];
      reports_due.delete(0);
      if (exp.status !== status || exp.front_value !== front || exp.back_value !== back ||
          exp.element_count !== count || exp.is_empty !== empty || exp.is_full !== full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch after %s (expected / actual)", $time, exp.cause_op.name());
          $display("  status %0d / %0d, front %0d / %0d, back %0d / %0d",
                   exp.status, status, exp.front_value, front, exp.back_value, back);
          $display("  count %0d / %0d, empty %0b / %0b, full %0b / %0b",
                   exp.element_count, count, exp.is_empty, empty, exp.is_full, full);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          in_opcode;
  logic signed [31:0]  in_data_value;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic signed [31:0]  out_front_value;
  logic signed [31:0]  out_back_value;
  logic [7:0]          out_element_count;
  logic                out_is_empty;
  logic                out_is_full;

  deque_scoreboard sb = new();
  int              items_sent = 0;
  int              cycle_count = 0;
  bit              calm = 1'b0;
  bit              hold_off_pending = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  circular_deque_engine_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_value     (in_data_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_report(out_status, out_front_value, out_back_value, out_element_count,
                      out_is_empty, out_is_full);
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] rand_word();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -1;
      3, 4: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic opcode_t rand_push();
    return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
  endfunction

  function automatic opcode_t rand_pop();
    return $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_BACK;
  endfunction

  // Ready side: random stalls, stretches without stalls, and one long hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall = idle_len();
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns right after the edge on which it transfers.
  task automatic send_item(opcode_t op, logic signed [31:0] value);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_data_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transfer(op, value);
    items_sent++;
    if (items_sent == HOLD_AT_ITEM) hold_off_pending = 1'b1;
  endtask

  // Pushes up to capacity, hits overflow from both ends, works near full,
  // then drains past empty.
  task automatic fill_and_drain(bit with_sort);
    int k;
    while (sb.depth < CAP) send_item(rand_push(), rand_word());
    send_item(OP_PUSH_REAR, rand_word());
    send_item(OP_PUSH_FRONT, rand_word());
    send_item(OP_PEEK, rand_word());
    send_item(OP_REVERSE, rand_word());
    if (with_sort) send_item(OP_SORT, rand_word());
    for (k = 0; k < 20; k++) begin
      case ($urandom_range(0, 3))
        0: send_item(rand_push(), rand_word());
        1: send_item(rand_pop(), rand_word());
        2: send_item(OP_PEEK, rand_word());
        default: send_item(OP_REVERSE, rand_word());
      endcase
    end
    while (sb.depth > 0) send_item(rand_pop(), rand_word());
    send_item(OP_POP_HEAD, rand_word());
    send_item(OP_POP_BACK, rand_word());
  endtask

  // Random mix that keeps the deque small so that sorts stay short.
  task automatic churn(int count);
    int k;
    int roll;
    opcode_t op;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) op = OP_PEEK;
      else if (roll < 7) op = OP_CLEAR;
      else if (roll < 13) op = (sb.depth <= SORT_DEPTH) ? OP_REVERSE : OP_POP_HEAD;
      else if (roll < 19) op = (sb.depth <= SORT_DEPTH) ? OP_SORT : OP_POP_BACK;
      else if ($urandom_range(0, 16) > sb.depth) op = rand_push();
      else op = rand_pop();
      send_item(op, rand_word());
    end
  endtask

  task automatic noise(int count);
    int k;
    opcode_t op;
    for (k = 0; k < count; k++) begin
      op = opcode_t'($urandom_range(0, 7));
      if ((op == OP_SORT || op == OP_REVERSE) && sb.depth > SORT_DEPTH) op = OP_PEEK;
      send_item(op, rand_word());
    end
  endtask

  initial begin
    int fills;
    int roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_PEEK;
    in_data_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-deque cases, signed extremes, one-element cases, clear.
    send_item(OP_PEEK, $urandom);
    send_item(OP_POP_HEAD, $urandom);
    send_item(OP_POP_BACK, $urandom);
    send_item(OP_PUSH_REAR, 32'sh7FFF_FFFF);
    send_item(OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(OP_PUSH_REAR, -1);
    send_item(OP_PUSH_FRONT, 0);
    send_item(OP_PEEK, $urandom);
    send_item(OP_REVERSE, $urandom);
    send_item(OP_SORT, $urandom);
    send_item(OP_POP_HEAD, $urandom);
    send_item(OP_POP_BACK, $urandom);
    send_item(OP_POP_BACK, $urandom);
    send_item(OP_POP_HEAD, $urandom);
    send_item(OP_POP_HEAD, $urandom);
    send_item(OP_REVERSE, $urandom);
    send_item(OP_SORT, $urandom);
    send_item(OP_PUSH_FRONT, 5);
    send_item(OP_REVERSE, $urandom);
    send_item(OP_SORT, $urandom);
    send_item(OP_PUSH_REAR, 5);
    send_item(OP_PUSH_REAR, -5);
    send_item(OP_SORT, $urandom);
    send_item(OP_CLEAR, $urandom);
    send_item(OP_PUSH_FRONT, 32'sh1234_5678);

    // The first fill also sorts a full deque; later fills only reverse it.
    fill_and_drain(1'b1);
    fills = 1;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 4 && fills < 3) begin
        fill_and_drain(1'b0);
        fills++;
      end else if (roll < 20) begin
        noise($urandom_range(10, 20));
      end else begin
        churn($urandom_range(20, 60));
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
